/* hdl/sas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and constants for the strongest attractor select block.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned RAD_W    = 12;
  localparam int unsigned STR_W    = 24;
  localparam int unsigned SELF_W   = 6;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned BEST_W   = 5;

  // distance datapath
  localparam int unsigned ABS_W      = POS_W;          // |dx|, |dy|
  localparam int unsigned SUM_W      = 2 * ABS_W + 2;  // dx^2 + dy^2, even width
  localparam int unsigned ROOT_W     = SUM_W / 2;
  localparam int unsigned REM_W      = ROOT_W + 3;
  localparam int unsigned SQRT_STEPS = SUM_W / 2;
  localparam int unsigned STEP_W     = $clog2(SQRT_STEPS);
  localparam int unsigned DIFF_W     = ROOT_W + 1;     // |root - radius|
  localparam int unsigned Q_W        = 2 * DIFF_W;
  localparam int unsigned HALF_W     = Q_W / 2;
  localparam int unsigned PART_W     = STR_W + HALF_W;
  localparam int unsigned CROSS_W    = STR_W + Q_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [RAD_W-1:0]        r;
    logic [STR_W-1:0]        s;
  } entry_t;

  typedef enum logic [2:0] {
    SC_IDLE, SC_SQ, SC_ROOT, SC_DIFF, SC_MUL, SC_DONE
  } score_state_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_SCORE, ST_MLO, ST_MHI, ST_CMP, ST_DONE
  } top_state_e;

  typedef struct packed {
    logic start;
  } score_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } score_stat_t;

endpackage

/* hdl/sas_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_in_if / sas_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface sas_in_if import sas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [RAD_W-1:0]        radius;
  logic [STR_W-1:0]        strength;
  logic [SELF_W-1:0]       self_index;

  modport source (output valid, cmd, pos_x, pos_y, radius, strength, self_index,
                  input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, radius, strength, self_index,
                  output ready);
endinterface

interface sas_out_if import sas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [BEST_W-1:0] best_index;

  modport source (output valid, status, found, best_index, input ready);
  modport sink   (input valid, status, found, best_index, output ready);
endinterface

/* hdl/strongest_attractor_select_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongest_attractor_select_core
// Attractor table held in a rotating ring of cells, with a query walker that
// scores each stored entry and keeps the first strongest one.
// ----------------------------------------------------------------------------
// Clear and append: result registered in the cycle after the item is accepted.
// Query: MAX_ENTRIES walk steps, and each scored entry runs through the distance
// scorer (17-step square root) and a compare in the MLO, MHI and CMP states;
// one item is in work at a time.
// Reset clears the entry count, the walker and the output valid; the table
// cells hold no reset and are only read below the count.
module strongest_attractor_select_core import sas_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  sas_in_if.sink    in_i,
  sas_out_if.source out_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  top_state_e st_q, st_d;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] walk_q;
  logic [IDX_W-1:0] cur_idx_q, best_idx_q;
  logic signed [POS_W-1:0] qx_q, qy_q;
  logic [SELF_W-1:0] self_q;
  logic [STR_W-1:0]  cur_s_q, bs_q;
  logic [Q_W-1:0]    bq_q;
  logic              have_q, binf_q;
  logic [PART_W-1:0] p1l_q, p2l_q, p1h_q, p2h_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic              out_found_q;
  logic [BEST_W-1:0] out_best_q;

  logic accept, out_free, shift, walk_end, eligible, better;
  logic [CROSS_W-1:0] lhs, rhs;
  logic [Q_W-1:0]     q;
  cmd_e               cmd;
  entry_t             load_data;
  entry_t             ring [MAX_ENTRIES];
  score_ctl_t         sc_ctl;
  score_stat_t        sc_stat;

  assign cmd      = cmd_e'(in_i.cmd);
  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign walk_end = (walk_q == CNT_W'(MAX_ENTRIES));
  assign eligible = (walk_q < count_q) && (32'(walk_q) != 32'(self_q));

  assign load_data.x = in_i.pos_x;
  assign load_data.y = in_i.pos_y;
  assign load_data.r = in_i.radius;
  assign load_data.s = in_i.strength;

  // Ring of cells: head is cell 0, each step every cell takes its neighbor,
  // so a full walk of MAX_ENTRIES steps leaves the table where it started.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    sas_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .load_i      (accept && (cmd == CMD_APPEND) &&
                    (count_q == CNT_W'(i))),
      .load_data_i (load_data),
      .chain_i     (ring[(i + 1) % MAX_ENTRIES]),
      .entry_o     (ring[i])
    );
  end

  sas_scorer u_scorer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sc_ctl),
    .entry_i (ring[0]),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .stat_o  (sc_stat),
    .q_o     (q)
  );

  // Exact cross-multiplied compare of s/q against best_s/best_q.
  assign lhs = CROSS_W'(p1l_q) + (CROSS_W'(p1h_q) << HALF_W);
  assign rhs = CROSS_W'(p2l_q) + (CROSS_W'(p2h_q) << HALF_W);
  assign better = !have_q || (!binf_q && ((q == '0) || (lhs > rhs)));

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (accept && (cmd == CMD_QUERY)) st_d = ST_WALK;
      ST_WALK: begin
        if (walk_end) begin
          st_d = ST_DONE;
        end else if (eligible) begin
          st_d = ST_SCORE;
        end
      end
      ST_SCORE: if (sc_stat.done) st_d = ST_MLO;
      ST_MLO:   st_d = ST_MHI;
      ST_MHI:   st_d = ST_CMP;
      ST_CMP:   st_d = ST_WALK;
      ST_DONE:  if (out_free) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    shift        = (st_q == ST_WALK) && !walk_end;
    sc_ctl.start = shift && eligible;
    in_i.ready   = (st_q == ST_IDLE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      have_q      <= 1'b0;
      binf_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      // clear, append and unused codes answer at once; a query answers when done
      if (accept && (cmd != CMD_QUERY)) begin
        out_valid_q <= 1'b1;
      end else if ((st_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        unique case (cmd)
          CMD_CLEAR: count_q <= '0;
          CMD_APPEND: begin
            if (count_q != CNT_W'(MAX_ENTRIES)) count_q <= count_q + 1'b1;
          end
          CMD_QUERY: begin
            walk_q <= '0;
            have_q <= 1'b0;
            binf_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (shift) walk_q <= walk_q + 1'b1;
      if ((st_q == ST_CMP) && better) begin
        have_q <= 1'b1;
        binf_q <= (q == '0);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q   <= in_i.pos_x;
      qy_q   <= in_i.pos_y;
      self_q <= in_i.self_index;
      out_status_q <= ((cmd == CMD_APPEND) && (count_q == CNT_W'(MAX_ENTRIES))) ?
                      STAT_FULL : STAT_OK;
      out_found_q  <= 1'b0;
      out_best_q   <= '0;
    end
    if (sc_ctl.start) begin
      cur_idx_q <= IDX_W'(walk_q);
      cur_s_q   <= ring[0].s;
    end
    if (st_q == ST_MLO) begin
      p1l_q <= cur_s_q * bq_q[HALF_W-1:0];
      p2l_q <= bs_q * q[HALF_W-1:0];
    end
    if (st_q == ST_MHI) begin
      p1h_q <= cur_s_q * bq_q[Q_W-1:HALF_W];
      p2h_q <= bs_q * q[Q_W-1:HALF_W];
    end
    if ((st_q == ST_CMP) && better) begin
      bs_q       <= cur_s_q;
      bq_q       <= q;
      best_idx_q <= cur_idx_q;
    end
    if ((st_q == ST_DONE) && out_free) begin
      out_found_q  <= have_q;
      out_status_q <= have_q ? STAT_OK : STAT_NONE;
      out_best_q   <= have_q ? BEST_W'(best_idx_q) : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.found      = out_found_q;
  assign out_o.best_index = out_best_q;

`ifndef SYNTHESIS
  // The entry count never runs past the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  // The scorer is only started while it is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_ctl.start |-> !sc_stat.busy)
    else $error("scorer started while busy");

  // Items are taken only with no query walk in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (st_q == ST_IDLE) && !sc_stat.busy)
    else $error("item taken during a query");

  // A walk step always follows a compare.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CMP) |=> (st_q == ST_WALK))
    else $error("compare not followed by walk");
`endif

endmodule

/* hdl/sas_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_cell
// One table slot of the entry ring: load from an append or take the neighbor.
// ----------------------------------------------------------------------------
module sas_cell import sas_pkg::*; (
  input  logic   clk_i,
  input  logic   shift_i,
  input  logic   load_i,
  input  entry_t load_data_i,
  input  entry_t chain_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= chain_i;
    end else if (load_i) begin
      entry_q <= load_data_i;
    end
  end

  assign entry_o = entry_q;

endmodule

/* hdl/sas_scorer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_scorer
// Forms q = (floor(sqrt(dx^2+dy^2)) - radius)^2 for one entry, 2 bits a step.
// ----------------------------------------------------------------------------
module sas_scorer import sas_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  score_ctl_t              ctl_i,
  input  entry_t                  entry_i,
  input  logic signed [POS_W-1:0] qx_i,
  input  logic signed [POS_W-1:0] qy_i,
  output score_stat_t             stat_o,
  output logic [Q_W-1:0]          q_o
);

  score_state_e st_q, st_d;
  logic [ABS_W-1:0]  ax_q, ay_q;
  logic [RAD_W-1:0]  r_q;
  logic [SUM_W-1:0]  n_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [STEP_W-1:0] step_q;
  logic [DIFF_W-1:0] ad_q;
  logic [Q_W-1:0]    q_q;

  logic signed [POS_W:0]  dx, dy;
  logic [REM_W-1:0]       rem_sh, trial;
  logic signed [DIFF_W:0] d;

  always_comb begin
    dx     = {entry_i.x[POS_W-1], entry_i.x} - {qx_i[POS_W-1], qx_i};
    dy     = {entry_i.y[POS_W-1], entry_i.y} - {qy_i[POS_W-1], qy_i};
    rem_sh = {rem_q[REM_W-3:0], n_q[SUM_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    d      = $signed({1'b0, root_q}) - $signed((DIFF_W + 1)'(r_q));
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SC_IDLE: if (ctl_i.start) st_d = SC_SQ;
      SC_SQ:   st_d = SC_ROOT;
      SC_ROOT: if (step_q == STEP_W'(SQRT_STEPS - 1)) st_d = SC_DIFF;
      SC_DIFF: st_d = SC_MUL;
      SC_MUL:  st_d = SC_DONE;
      SC_DONE: st_d = SC_IDLE;
      default: st_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SC_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      SC_IDLE: begin
        ax_q <= dx[POS_W] ? ABS_W'(-dx) : ABS_W'(dx);
        ay_q <= dy[POS_W] ? ABS_W'(-dy) : ABS_W'(dy);
        r_q  <= entry_i.r;
      end
      SC_SQ: begin
        n_q    <= SUM_W'(ax_q * ax_q) + SUM_W'(ay_q * ay_q);
        rem_q  <= '0;
        root_q <= '0;
        step_q <= '0;
      end
      SC_ROOT: begin
        // restoring square root, one result bit per step
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
        n_q    <= {n_q[SUM_W-3:0], 2'b00};
        step_q <= step_q + 1'b1;
      end
      SC_DIFF: ad_q <= d[DIFF_W] ? DIFF_W'(-d) : DIFF_W'(d);
      SC_MUL:  q_q  <= ad_q * ad_q;
      default: ;
    endcase
  end

  assign stat_o.busy = (st_q != SC_IDLE);
  assign stat_o.done = (st_q == SC_DONE);
  assign q_o         = q_q;

endmodule

/* tb/strongest_attractor_select_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongest_attractor_select_core_test
// Self-checking bench for the attractor table and its strongest-entry query.
// A predictor keeps its own table, scores every query exactly, and each
// result item is compared with the oldest pending answer. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module strongest_attractor_select_core_test;
  import sas_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [BEST_W-1:0] best;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  sas_in_if  cmd_if ();
  sas_out_if res_if ();

  strongest_attractor_select_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if.sink),
    .out_o (res_if.source)
  );

  // Predictor's own copy of the table.
  logic signed [POS_W-1:0] tab_x[TABLE_DEPTH];
  logic signed [POS_W-1:0] tab_y[TABLE_DEPTH];
  logic [RAD_W-1:0]        tab_r[TABLE_DEPTH];
  logic [STR_W-1:0]        tab_s[TABLE_DEPTH];
  int unsigned             tab_count;

  answer_t pending_answers[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hits, misses, drops, infinite_hits;
  bit          calm;  // stretch with no idling on either side

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Integer floor square root, one result bit per pass.
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Apply one item to the predicted table and work out its result.
  function automatic answer_t apply_command(input cmd_e c, input logic signed [POS_W-1:0] px,
                                            input logic signed [POS_W-1:0] py,
                                            input logic [RAD_W-1:0] rad,
                                            input logic [STR_W-1:0] str,
                                            input logic [SELF_W-1:0] skip);
    answer_t a;
    bit have, best_inf;
    longint unsigned best_s, best_q, q, s, root;
    longint signed dx, dy, d;
    bit better;
    a = '{status: STAT_OK, found: 1'b0, best: '0};
    have = 0;
    best_inf = 0;
    best_s = 0;
    best_q = 1;
    case (c)
      CMD_CLEAR: tab_count = 0;
      CMD_APPEND: begin
        if (tab_count < TABLE_DEPTH) begin
          tab_x[tab_count] = px;
          tab_y[tab_count] = py;
          tab_r[tab_count] = rad;
          tab_s[tab_count] = str;
          tab_count++;
        end else begin
          a.status = STAT_FULL;
          drops++;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < tab_count; i++) begin
          if (i == skip) continue;
          dx = longint'(tab_x[i]) - longint'(px);
          dy = longint'(tab_y[i]) - longint'(py);
          root = floor_root(longint'(dx * dx) + longint'(dy * dy));
          d = longint'(root) - longint'(tab_r[i]);
          q = d * d;
          s = tab_s[i];
          if (!have) better = 1;
          else if (best_inf) better = 0;
          else if (q == 0) better = 1;
          else better = (s * best_q) > (best_s * q);
          if (better) begin
            have = 1;
            best_inf = (q == 0);
            best_s = s;
            best_q = q;
            a.best = i[BEST_W-1:0];
          end
        end
        if (have) begin
          a.found = 1'b1;
          hits++;
          if (best_inf) infinite_hits++;
        end else begin
          a.status = STAT_NONE;
          a.best = '0;
          misses++;
        end
      end
      default: ;  // unused command: state unchanged
    endcase
    return a;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Send one item; the caller is always just past a rising edge.
  task automatic send_item(input cmd_e c, input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] py, input logic [RAD_W-1:0] rad,
                           input logic [STR_W-1:0] str, input logic [SELF_W-1:0] skip);
    int unsigned gap;
    answer_t expected;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.cmd        <= c;
    cmd_if.pos_x      <= px;
    cmd_if.pos_y      <= py;
    cmd_if.radius     <= rad;
    cmd_if.strength   <= str;
    cmd_if.self_index <= skip;
    // Values read right after the edge are the ones the block sampled.
    do @(posedge clk_i); while (!cmd_if.ready);
    expected = apply_command(c, px, py, rad, str, skip);
    pending_answers = {pending_answers, expected};
    items_sent++;
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls on ready, and a check on every accepted item.
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result with nothing pending: status %0d found %0d best %0d",
                     res_if.status, res_if.found, res_if.best_index);
        end else begin
          exp_a = pending_answers.pop_front();
          if (res_if.status !== exp_a.status || res_if.found !== exp_a.found ||
              res_if.best_index !== exp_a.best) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d: expected status %0d found %0d best %0d, got %0d %0d %0d",
                       results_seen, exp_a.status, exp_a.found, exp_a.best,
                       res_if.status, res_if.found, res_if.best_index);
          end
        end
      end
      // Hold ready low for a drawn number of cycles, then release it.
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 30) begin
        stall_left = ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(50, 10);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles, %0d answers pending",
                 IDLE_LIMIT, pending_answers.size());
        $display("strongest_attractor_select_core_test failed");
        $finish;
      end
    end
  end

  function automatic logic [STR_W-1:0] rand_strength();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 5) return STR_W'($urandom_range(4095));
    return STR_W'($urandom());
  endfunction

  // Table basics: empty query, unused command, clear, and append results.
  task automatic test_basics();
    send_item(CMD_QUERY, 16'sd0, 16'sd0, '0, '0, 6'd32);
    send_item(CMD_NONE, 16'sh7FFF, -16'sh8000, '1, '1, 6'd63);
    send_item(CMD_APPEND, -16'sh8000, -16'sh8000, '1, '1, 6'd0);
    send_item(CMD_APPEND, 16'sh7FFF, 16'sh7FFF, '0, 24'd1, 6'd0);
    // farthest possible query distance
    send_item(CMD_QUERY, 16'sh7FFF, 16'sh7FFF, '0, '0, 6'd63);
    send_item(CMD_QUERY, -16'sh8000, 16'sh7FFF, '0, '0, 6'd32);
    send_item(CMD_CLEAR, 16'sd0, 16'sd0, '0, '0, 6'd0);
    send_item(CMD_QUERY, 16'sd5, 16'sd5, '0, '0, 6'd32);
  endtask

  // Zero distance wins even with zero strength; a later one does not replace it;
  // the skipped index and the lone-self query; entries 3 and 4 tie behind entry 2.
  task automatic test_scoring();
    send_item(CMD_APPEND, 16'sd100, 16'sd0, 12'd10, 24'hFFFFFF, 6'd0);
    send_item(CMD_QUERY, 16'sd100, 16'sd0, '0, '0, 6'd0);   // only self -> none
    send_item(CMD_APPEND, 16'sd0, 16'sd0, 12'd5, 24'd0, 6'd0);
    send_item(CMD_APPEND, 16'sd0, 16'sd3, 12'd2, 24'd7, 6'd0);
    send_item(CMD_QUERY, 16'sd5, 16'sd0, '0, '0, 6'd32);    // entry 1 at distance == radius
    send_item(CMD_QUERY, 16'sd0, 16'sd5, '0, '0, 6'd1);     // entry 2 infinite, 1 skipped
    send_item(CMD_APPEND, 16'sd0, 16'sd40, 12'd0, 24'd7, 6'd0);
    send_item(CMD_APPEND, 16'sd0, -16'sd40, 12'd0, 24'd7, 6'd0);
    send_item(CMD_QUERY, 16'sd0, 16'sd0, '0, '0, 6'd62);    // tie between entries 3 and 4
    send_item(CMD_CLEAR, 16'sd0, 16'sd0, '0, '0, 6'd0);
  endtask

  // Fill the table, overflow it, and query at the last slot with that slot skipped.
  task automatic test_full_table();
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(CMD_APPEND, POS_W'($urandom()), POS_W'($urandom()), RAD_W'($urandom()),
                rand_strength(), '0);
    send_item(CMD_APPEND, 16'sd1, 16'sd1, 12'd1, 24'd1, 6'd0);
    send_item(CMD_QUERY, tab_x[TABLE_DEPTH-1], tab_y[TABLE_DEPTH-1], '0, '0, 6'd31);
    send_item(CMD_QUERY, 16'sd0, 16'sd0, '0, '0, 6'd31);
  endtask

  // Random sessions: clear, build a table of drawn size, then mixed traffic.
  task automatic test_random_traffic();
    int unsigned target, roll, k, gap_draw;
    logic signed [POS_W-1:0] qx, qy;
    bit local_area;
    target = 4;
    local_area = 1;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 3) calm = ~calm;
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_item(CMD_CLEAR, POS_W'($urandom()), POS_W'($urandom()), RAD_W'($urandom()),
                  STR_W'($urandom()), SELF_W'($urandom()));
        // mostly small tables, sometimes full or overfull
        gap_draw = $urandom_range(9);
        target = (gap_draw < 6) ? $urandom_range(6, 1) : (gap_draw < 8) ?
                 $urandom_range(16, 7) : $urandom_range(36, 28);
        local_area = 1'($urandom_range(1));
      end else if (roll < 7) begin
        send_item(CMD_NONE, POS_W'($urandom()), POS_W'($urandom()), RAD_W'($urandom()),
                  STR_W'($urandom()), SELF_W'($urandom()));
      end else if (roll < 55 && tab_count < target) begin
        if (local_area)
          send_item(CMD_APPEND, POS_W'($urandom_range(400)) - 16'sd200,
                    POS_W'($urandom_range(400)) - 16'sd200, RAD_W'($urandom_range(100)),
                    rand_strength(), SELF_W'($urandom()));
        else
          send_item(CMD_APPEND, POS_W'($urandom()), POS_W'($urandom()), RAD_W'($urandom()),
                    rand_strength(), SELF_W'($urandom()));
      end else begin
        // Aim queries: anywhere, near an entry, exactly on an entry's rim, or in the local area.
        qx = POS_W'($urandom());
        qy = POS_W'($urandom());
        if (tab_count > 0) begin
          k = $urandom_range(tab_count - 1);
          gap_draw = $urandom_range(3);
          if (gap_draw == 1) begin
            qx = tab_x[k] + POS_W'($urandom_range(300)) - 16'sd150;
            qy = tab_y[k] + POS_W'($urandom_range(300)) - 16'sd150;
          end else if (gap_draw == 2) begin
            qx = tab_x[k] + POS_W'(tab_r[k]);
            qy = tab_y[k];
          end else if (gap_draw == 3 && local_area) begin
            qx = POS_W'($urandom_range(400)) - 16'sd200;
            qy = POS_W'($urandom_range(400)) - 16'sd200;
          end
        end
        send_item(CMD_QUERY, qx, qy, RAD_W'($urandom()), STR_W'($urandom()),
                  ($urandom_range(1) && tab_count > 0) ? SELF_W'($urandom_range(tab_count - 1))
                                                       : SELF_W'($urandom()));
      end
    end
    calm = 0;
  endtask

  initial begin
    cmd_if.valid      <= 1'b0;
    cmd_if.cmd        <= CMD_CLEAR;
    cmd_if.pos_x      <= '0;
    cmd_if.pos_y      <= '0;
    cmd_if.radius     <= '0;
    cmd_if.strength   <= '0;
    cmd_if.self_index <= '0;
    rst_ni = 1'b0;
    tab_count = 0;
    mismatches = 0;
    idle_cycles = 0;
    items_sent = 0;
    results_seen = 0;
    hits = 0;
    misses = 0;
    drops = 0;
    infinite_hits = 0;
    calm = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basics();
    test_scoring();
    test_full_table();
    test_random_traffic();

    cmd_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results, %0d mismatches.",
             items_sent, results_seen, mismatches);
    $display("Queries: %0d found (%0d at zero distance), %0d empty; %0d appends dropped full.",
             hits, infinite_hits, misses, drops);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("strongest_attractor_select_core_test passed");
    end else begin
      $display("strongest_attractor_select_core_test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/sas_pkg.sv
hdl/sas_if.sv
hdl/sas_cell.sv
hdl/sas_scorer.sv
hdl/strongest_attractor_select_core.sv
tb/strongest_attractor_select_core_test.sv
